### hw/rtl/ncq_pkg.sv
// Shared constants, command codes and types of the nearest colliding obstacle query core.
// Used by ncq_cell and nearest_colliding_obstacle_query_core; depends on nothing.
`default_nettype none

package ncq_pkg;

    // Table depth default
    localparam int MAX_ENTRIES_DEF = 16;

    // Field widths
    localparam int CMD_W     = 2;
    localparam int POS_W     = 12;
    localparam int HALF_W    = 10;
    localparam int COLOR_W   = 2;
    localparam int QPOS_W    = 14;
    localparam int RAD_W     = 10;
    localparam int HIT_IDX_W = 4;
    localparam int COUNT_W   = 5;

    // Datapath widths: signed difference, its magnitude, squares and sums
    localparam int DIFF_W    = 15;
    localparam int ADIFF_W   = 14;
    localparam int SQ_W      = 28;
    localparam int D2_W      = 29;
    localparam int SUM_W     = 11;
    localparam int THR_W     = 22;
    // Index carried by the scan token, enough for 256 entries
    localparam int TOK_IDX_W = 8;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    // Pawn radius after reset
    localparam logic [RAD_W-1:0] PAWN_RESET = 10'd100;

    // One stored obstacle
    typedef struct packed {
        logic               kind;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [HALF_W-1:0]  half_x;
        logic [HALF_W-1:0]  half_y;
        logic [COLOR_W-1:0] color;
    } t_entry;

    // Query request as seen by every cell
    typedef struct packed {
        logic signed [QPOS_W-1:0] x;
        logic signed [QPOS_W-1:0] y;
        logic [RAD_W-1:0]         radius;
        logic [COLOR_W-1:0]       color;
        logic [RAD_W-1:0]         pawn;
    } t_query;

    // Running best match handed from cell to cell
    typedef struct packed {
        logic                 valid;
        logic                 hit;
        logic [D2_W-1:0]      best;
        logic [TOK_IDX_W-1:0] idx;
    } t_token;

endpackage

`default_nettype wire

### hw/rtl/ncq_cell.sv
// One table cell: holds a single obstacle, computes its collision distance, and merges
// its result into the scan token passed down the chain. Depends on ncq_pkg.
`default_nettype none

module ncq_cell
    import ncq_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_wr,
    input  wire t_entry i_entry,
    input  wire logic   i_used,
    input  wire t_query i_query,
    input  wire t_token i_tok,
    output t_token      o_tok
);

    t_entry                    r_entry;
    logic signed [DIFF_W-1:0]  w_dx;
    logic signed [DIFF_W-1:0]  w_dy;
    logic signed [DIFF_W-1:0]  w_ndx;
    logic signed [DIFF_W-1:0]  w_ndy;
    logic [ADIFF_W-1:0]        w_adx;
    logic [ADIFF_W-1:0]        w_ady;
    logic [HALF_W-1:0]         w_side;
    logic [SUM_W-1:0]          w_sum;
    logic [SQ_W-1:0]           r_dx2;
    logic [SQ_W-1:0]           r_dy2;
    logic [THR_W-1:0]          r_thr;
    logic [D2_W-1:0]           w_d2;
    logic [D2_W-1:0]           r_d2;
    logic                      r_ok;
    logic                      w_take;
    logic                      r_valid;
    logic                      r_hit;
    logic [D2_W-1:0]           r_best;
    logic [TOK_IDX_W-1:0]      r_idx;

    // Store the entry on append
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_entry <= i_entry;
        end
    end

    // Distance components and collision radius
    always_comb begin
        w_dx   = DIFF_W'(i_query.x) - $signed({3'b000, r_entry.x});
        w_dy   = DIFF_W'(i_query.y) - $signed({3'b000, r_entry.y});
        w_ndx  = -w_dx;
        w_ndy  = -w_dy;
        w_adx  = w_dx[DIFF_W-1] ? w_ndx[ADIFF_W-1:0] : w_dx[ADIFF_W-1:0];
        w_ady  = w_dy[DIFF_W-1] ? w_ndy[ADIFF_W-1:0] : w_dy[ADIFF_W-1:0];
        // Both rectangle tests pass exactly when the smaller half side passes
        if (r_entry.kind) begin
            w_side = (r_entry.half_x < r_entry.half_y) ? r_entry.half_x : r_entry.half_y;
        end else begin
            w_side = i_query.pawn;
        end
        w_sum  = SUM_W'(w_side) + SUM_W'(i_query.radius);
    end

    // Stage one: squares
    always_ff @(posedge i_clk) begin
        r_dx2 <= SQ_W'(w_adx) * SQ_W'(w_adx);
        r_dy2 <= SQ_W'(w_ady) * SQ_W'(w_ady);
        r_thr <= THR_W'(w_sum) * THR_W'(w_sum);
    end

    // Stage two: squared distance and collision flag
    assign w_d2 = D2_W'(r_dx2) + D2_W'(r_dy2);

    always_ff @(posedge i_clk) begin
        r_d2 <= w_d2;
        r_ok <= i_used && (r_entry.color == i_query.color) && (w_d2 < D2_W'(r_thr));
    end

    // Take over the token when strictly nearer, so earlier entries win ties
    assign w_take = r_ok && (!i_tok.hit || (r_d2 < i_tok.best));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_tok.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_hit  <= 1'b1;
            r_best <= r_d2;
            r_idx  <= TOK_IDX_W'(INDEX);
        end else begin
            r_hit  <= i_tok.hit;
            r_best <= i_tok.best;
            r_idx  <= i_tok.idx;
        end
    end

    assign o_tok = '{valid: r_valid, hit: r_hit, best: r_best, idx: r_idx};

endmodule

`default_nettype wire

### hw/rtl/nearest_colliding_obstacle_query_core.sv
// Top level of the nearest colliding obstacle query core: command decode, entry count,
// pawn radius register and the chain of ncq_cell instances. Depends on ncq_pkg, ncq_cell.
`default_nettype none

// Usage
// - Command channel: drive i_cmd and the payload with start high; the request is taken
//   at a clock edge where start is high and busy is low.
// - Clear and append finish at once: o_done pulses in the cycle after the request, with
//   o_entry_count giving the count after the command, and busy stays low, so one such
//   request can be taken every cycle. An append to a full table raises o_table_full.
// - A query broadcasts the circle to all cells, which compute their squared distance
//   and collision test in two stages, then a token carrying the best match walks the
//   chain one cell per cycle. busy stays high from the request until the o_done pulse,
//   so no new request is taken before the token walk through the cell chain ends.
// - Each result is on the o_ ports for exactly one cycle, marked by o_done; the
//   receiver cannot stall it and must take it in that cycle.
// - Configuration: i_cfg_valid / o_cfg_ready write the pawn radius (reset 100); it is
//   read at query time and applies to stored circle entries too.
// - Reset (i_rst_n low, synchronous) empties the table and returns to idle; stored
//   entry contents are not cleared, only the count.

module nearest_colliding_obstacle_query_core
    import ncq_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // Command channel
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [CMD_W-1:0]         i_cmd,
    input  wire logic                     i_kind,
    input  wire logic [POS_W-1:0]         i_entry_x,
    input  wire logic [POS_W-1:0]         i_entry_y,
    input  wire logic [HALF_W-1:0]        i_half_x,
    input  wire logic [HALF_W-1:0]        i_half_y,
    input  wire logic [COLOR_W-1:0]       i_entry_color,
    input  wire logic signed [QPOS_W-1:0] i_query_x,
    input  wire logic signed [QPOS_W-1:0] i_query_y,
    input  wire logic [RAD_W-1:0]         i_query_radius,
    input  wire logic [COLOR_W-1:0]       i_query_color,
    // Result
    output logic                          o_done,
    output logic                          o_hit,
    output logic [HIT_IDX_W-1:0]          o_hit_index,
    output logic                          o_table_full,
    output logic [COUNT_W-1:0]            o_entry_count,
    // Configuration
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [RAD_W-1:0]         i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                  r_state;
    logic [CNT_W-1:0]      r_count;
    logic [RAD_W-1:0]      r_pawn;
    t_query                r_query;
    logic [2:0]            r_go;
    logic                  r_done;
    logic                  r_hit;
    logic [HIT_IDX_W-1:0]  r_hit_index;
    logic                  r_full;
    logic                  w_accept;
    logic                  w_is_full;
    t_entry                w_entry;
    logic [MAX_ENTRIES-1:0] w_wr;
    logic [MAX_ENTRIES-1:0] w_used;
    t_token                w_tok [0:MAX_ENTRIES];

    assign busy        = (r_state == ST_SCAN);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign w_accept    = start && !busy;
    assign w_is_full   = (r_count == CNT_W'(MAX_ENTRIES));

    assign w_entry = '{kind: i_kind, x: i_entry_x, y: i_entry_y, half_x: i_half_x,
                       half_y: i_half_y, color: i_entry_color};

    // Pawn radius register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pawn <= PAWN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_pawn <= i_cfg_data;
        end
    end

    // Hold the query for the whole scan
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_query <= '{x: i_query_x, y: i_query_y, radius: i_query_radius,
                         color: i_query_color, pawn: r_pawn};
        end
    end

    // Launch the token once both cell stages have settled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go <= '0;
        end else begin
            r_go <= {r_go[1:0], w_accept && (i_cmd == CMD_QUERY)};
        end
    end

    assign w_tok[0] = '{valid: r_go[2], hit: 1'b0, best: '0, idx: '0};

    // Cell chain
    for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
        assign w_wr[k]   = w_accept && (i_cmd == CMD_APPEND) && (r_count == CNT_W'(k));
        assign w_used[k] = (r_count > CNT_W'(k));

        ncq_cell #(
            .INDEX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (w_wr[k]),
            .i_entry (w_entry),
            .i_used  (w_used[k]),
            .i_query (r_query),
            .i_tok   (w_tok[k]),
            .o_tok   (w_tok[k+1])
        );
    end

    // Command sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (r_state == ST_SCAN) begin
                // Drop the result when the token leaves the last cell
                if (w_tok[MAX_ENTRIES].valid) begin
                    r_state     <= ST_IDLE;
                    r_done      <= 1'b1;
                    r_hit       <= w_tok[MAX_ENTRIES].hit;
                    r_hit_index <= w_tok[MAX_ENTRIES].idx[HIT_IDX_W-1:0];
                    r_full      <= 1'b0;
                end
            end else if (w_accept) begin
                r_hit       <= 1'b0;
                r_hit_index <= '0;
                r_full      <= 1'b0;
                case (i_cmd)
                    CMD_CLEAR: begin
                        r_count <= '0;
                        r_done  <= 1'b1;
                    end
                    CMD_APPEND: begin
                        r_done <= 1'b1;
                        if (w_is_full) begin
                            r_full <= 1'b1;
                        end else begin
                            r_count <= r_count + CNT_W'(1);
                        end
                    end
                    CMD_QUERY: begin
                        r_state <= ST_SCAN;
                    end
                    default: begin
                        r_done <= 1'b1;
                    end
                endcase
            end
        end
    end

    assign o_done        = r_done;
    assign o_hit         = r_hit;
    assign o_hit_index   = r_hit_index;
    assign o_table_full  = r_full;
    assign o_entry_count = COUNT_W'(r_count);

endmodule

`default_nettype wire

### dv/nearest_colliding_obstacle_query_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for nearest_colliding_obstacle_query_core: clear, append, query and
// no-op requests plus pawn radius writes, each result checked against an in-bench table.
// Depends on ncq_pkg and the core RTL.

module nearest_colliding_obstacle_query_core_test;
    import ncq_pkg::*;

    localparam int TABLE_DEPTH     = MAX_ENTRIES_DEF;
    localparam int SETTLE_CYCLES   = TABLE_DEPTH + 8;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int MAX_REPORTS     = 10;

    // Unused command code: the core answers with the count only
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

    localparam logic KIND_CIRCLE = 1'b0;
    localparam logic KIND_RECT   = 1'b1;

    localparam logic [COLOR_W-1:0] COLOR_NEUTRAL = 2'd0;
    localparam logic [COLOR_W-1:0] COLOR_RED     = 2'd1;
    localparam logic [COLOR_W-1:0] COLOR_BLUE    = 2'd2;
    localparam logic [COLOR_W-1:0] COLOR_BLACK   = 2'd3;

    // One command request as driven on the ports
    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        t_entry                   entry;
        logic signed [QPOS_W-1:0] qx;
        logic signed [QPOS_W-1:0] qy;
        logic [RAD_W-1:0]         radius;
        logic [COLOR_W-1:0]       qcolor;
    } t_request;

    // One command result
    typedef struct packed {
        logic                 hit;
        logic [HIT_IDX_W-1:0] hit_index;
        logic                 table_full;
        logic [COUNT_W-1:0]   entry_count;
    } t_outcome;

    // Obstacle table mirror: predicts each result and checks the core's answers
    class obstacle_result_checker;
        t_entry           obstacles [TABLE_DEPTH];
        int unsigned      held;
        logic [RAD_W-1:0] pawn;
        t_outcome         pending [$];
        int unsigned      mismatches;
        int unsigned      queries;
        int unsigned      hits;
        int unsigned      drops;
        int unsigned      clears;

        function new();
            held       = 0;
            pawn       = PAWN_RESET;
            mismatches = 0;
            queries    = 0;
            hits       = 0;
            drops      = 0;
            clears     = 0;
        endfunction

        function void set_pawn(logic [RAD_W-1:0] value);
            pawn = value;
        endfunction

        // Apply an accepted request to the table and queue its expected result
        function void note_command(t_request r);
            t_outcome want;
            longint   dx;
            longint   dy;
            longint   d2;
            longint   best;
            longint   reach;
            bit       ok;
            want = '0;
            best = 0;
            case (r.cmd)
                CMD_CLEAR: begin
                    held = 0;
                    clears++;
                end
                CMD_APPEND: begin
                    if (held >= TABLE_DEPTH) begin
                        want.table_full = 1'b1;
                        drops++;
                    end else begin
                        obstacles[held] = r.entry;
                        held++;
                    end
                end
                CMD_QUERY: begin
                    queries++;
                    for (int i = 0; i < held; i++) begin
                        if (obstacles[i].color != r.qcolor) continue;
                        dx = longint'($signed(r.qx)) - longint'(obstacles[i].x);
                        dy = longint'($signed(r.qy)) - longint'(obstacles[i].y);
                        d2 = dx * dx + dy * dy;
                        if (obstacles[i].kind == KIND_CIRCLE) begin
                            reach = longint'(pawn) + longint'(r.radius);
                            ok = d2 < reach * reach;
                        end else begin
                            reach = longint'(obstacles[i].half_x) + longint'(r.radius);
                            ok = d2 < reach * reach;
                            reach = longint'(obstacles[i].half_y) + longint'(r.radius);
                            ok = ok && (d2 < reach * reach);
                        end
                        // Keep the earliest entry on equal distance
                        if (ok && (!want.hit || d2 < best)) begin
                            want.hit       = 1'b1;
                            want.hit_index = HIT_IDX_W'(i);
                            best           = d2;
                        end
                    end
                    if (want.hit) hits++;
                end
                default: ;
            endcase
            want.entry_count = COUNT_W'(held);
            pending = {pending, want};
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
        endfunction

        // Compare one result with the oldest expectation
        function void check_result(t_outcome got);
            t_outcome want;
            if (pending.size() == 0) begin
                report($sformatf("result with nothing pending: hit=%0d idx=%0d full=%0d count=%0d",
                                 got.hit, got.hit_index, got.table_full, got.entry_count));
                return;
            end
            want = pending.pop_front();
            if (got.hit !== want.hit || got.hit_index !== want.hit_index ||
                got.table_full !== want.table_full || got.entry_count !== want.entry_count) begin
                report($sformatf({"expected hit=%0d idx=%0d full=%0d count=%0d, ",
                                  "got hit=%0d idx=%0d full=%0d count=%0d"},
                                 want.hit, want.hit_index, want.table_full, want.entry_count,
                                 got.hit, got.hit_index, got.table_full, got.entry_count));
            end
        endfunction

        // Count expectations that never got a result
        function void close();
            if (pending.size() != 0)
                report($sformatf("%0d results never arrived", pending.size()));
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n        = 1'b0;
    logic                     start          = 1'b0;
    logic                     busy;
    logic [CMD_W-1:0]         i_cmd          = '0;
    logic                     i_kind         = 1'b0;
    logic [POS_W-1:0]         i_entry_x      = '0;
    logic [POS_W-1:0]         i_entry_y      = '0;
    logic [HALF_W-1:0]        i_half_x       = '0;
    logic [HALF_W-1:0]        i_half_y       = '0;
    logic [COLOR_W-1:0]       i_entry_color  = '0;
    logic signed [QPOS_W-1:0] i_query_x      = '0;
    logic signed [QPOS_W-1:0] i_query_y      = '0;
    logic [RAD_W-1:0]         i_query_radius = '0;
    logic [COLOR_W-1:0]       i_query_color  = '0;
    logic                     o_done;
    logic                     o_hit;
    logic [HIT_IDX_W-1:0]     o_hit_index;
    logic                     o_table_full;
    logic [COUNT_W-1:0]       o_entry_count;
    logic                     i_cfg_valid    = 1'b0;
    logic                     o_cfg_ready;
    logic [RAD_W-1:0]         i_cfg_data     = '0;

    obstacle_result_checker sb = new();
    int unsigned cycle_count = 0;
    int unsigned pawn_writes = 0;

    nearest_colliding_obstacle_query_core #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_kind         (i_kind),
        .i_entry_x      (i_entry_x),
        .i_entry_y      (i_entry_y),
        .i_half_x       (i_half_x),
        .i_half_y       (i_half_y),
        .i_entry_color  (i_entry_color),
        .i_query_x      (i_query_x),
        .i_query_y      (i_query_y),
        .i_query_radius (i_query_radius),
        .i_query_color  (i_query_color),
        .o_done         (o_done),
        .o_hit          (o_hit),
        .o_hit_index    (o_hit_index),
        .o_table_full   (o_table_full),
        .o_entry_count  (o_entry_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Check each strobed result
    always @(posedge i_clk) begin
        t_outcome got;
        if (i_rst_n && o_done === 1'b1) begin
            got.hit         = o_hit;
            got.hit_index   = o_hit_index;
            got.table_full  = o_table_full;
            got.entry_count = o_entry_count;
            sb.check_result(got);
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     sb.pending.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic t_request make_request(logic [CMD_W-1:0] cmd);
        t_request r;
        r     = '0;
        r.cmd = cmd;
        return r;
    endfunction

    function automatic t_request make_append(logic kind, int x, int y, int hx, int hy,
                                             logic [COLOR_W-1:0] color);
        t_request r;
        r              = make_request(CMD_APPEND);
        r.entry.kind   = kind;
        r.entry.x      = POS_W'(x);
        r.entry.y      = POS_W'(y);
        r.entry.half_x = HALF_W'(hx);
        r.entry.half_y = HALF_W'(hy);
        r.entry.color  = color;
        return r;
    endfunction

    function automatic t_request make_query(int x, int y, int radius,
                                            logic [COLOR_W-1:0] color);
        t_request r;
        r        = make_request(CMD_QUERY);
        r.qx     = QPOS_W'(x);
        r.qy     = QPOS_W'(y);
        r.radius = RAD_W'(radius);
        r.qcolor = color;
        return r;
    endfunction

    // Build a random request, mostly appends and queries aimed near stored entries
    function automatic t_request random_request(int clear_pct);
        t_request r;
        t_entry   near;
        int       roll;
        r.entry.kind   = 1'($urandom_range(0, 1));
        r.entry.x      = POS_W'($urandom_range(0, 4095));
        r.entry.y      = POS_W'($urandom_range(0, 4095));
        r.entry.half_x = HALF_W'($urandom_range(0, 1023));
        r.entry.half_y = HALF_W'($urandom_range(0, 1023));
        r.entry.color  = COLOR_W'($urandom_range(0, 3));
        r.qx           = QPOS_W'(int'($urandom_range(0, 12287)) - 4096);
        r.qy           = QPOS_W'(int'($urandom_range(0, 12287)) - 4096);
        r.radius       = RAD_W'($urandom_range(0, 1023));
        r.qcolor       = COLOR_W'($urandom_range(0, 3));
        roll           = int'($urandom_range(0, 99));
        if (roll < clear_pct) begin
            r.cmd = CMD_CLEAR;
        end else if (roll < clear_pct + 4) begin
            r.cmd = CMD_NOP;
        end else if (roll < 45) begin
            r.cmd = CMD_APPEND;
            if (sb.held > 0 && sb.held < TABLE_DEPTH && $urandom_range(0, 6) == 0) begin
                // Duplicate a stored entry to force distance ties
                r.entry = sb.obstacles[$urandom_range(0, sb.held - 1)];
            end else if ($urandom_range(0, 1) == 0) begin
                r.entry.half_x = HALF_W'($urandom_range(0, 300));
                r.entry.half_y = HALF_W'($urandom_range(0, 300));
            end
        end else begin
            r.cmd = CMD_QUERY;
            if (sb.held > 0 && $urandom_range(0, 3) != 0) begin
                near = sb.obstacles[$urandom_range(0, sb.held - 1)];
                r.qx = QPOS_W'(int'(near.x) + int'($urandom_range(0, 1200)) - 600);
                r.qy = QPOS_W'(int'(near.y) + int'($urandom_range(0, 1200)) - 600);
                if ($urandom_range(0, 6) != 0) r.qcolor = near.color;
            end
            if ($urandom_range(0, 9) < 7) r.radius = RAD_W'($urandom_range(0, 400));
        end
        return r;
    endfunction

    // Hold a request on the ports until the core takes it; leave start high
    task automatic issue(t_request r);
        start          <= 1'b1;
        i_cmd          <= r.cmd;
        i_kind         <= r.entry.kind;
        i_entry_x      <= r.entry.x;
        i_entry_y      <= r.entry.y;
        i_half_x       <= r.entry.half_x;
        i_half_y       <= r.entry.half_y;
        i_entry_color  <= r.entry.color;
        i_query_x      <= r.qx;
        i_query_y      <= r.qy;
        i_query_radius <= r.radius;
        i_query_color  <= r.qcolor;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_command(r);
    endtask

    // Drop start and let the clock run; n, at least one, sets how long
    task automatic pause(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Drop start and wait until every pending result has come back
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_pawn(logic [RAD_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        sb.set_pawn(value);
        pawn_writes++;
        @(posedge i_clk);
    endtask

    initial begin
        logic [RAD_W-1:0] pawn_plan [RANDOM_PHASES];
        int               sent;
        int               burst;
        int               gap;
        int               clear_pct;
        t_request         r;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, no-op, extremes, boundaries, ties, full table
        write_pawn(PAWN_RESET);
        issue(make_query(0, 0, 1023, COLOR_NEUTRAL));
        r = random_request(0);
        r.cmd = CMD_NOP;
        issue(r);
        issue(make_append(KIND_CIRCLE, 0, 0, 0, 0, COLOR_NEUTRAL));
        issue(make_append(KIND_RECT, 4095, 4095, 1023, 1023, COLOR_BLACK));
        issue(make_append(KIND_RECT, 2000, 2000, 0, 0, COLOR_RED));
        issue(make_append(KIND_CIRCLE, 2048, 2048, 1023, 1023, COLOR_BLUE));
        issue(make_append(KIND_CIRCLE, 0, 0, 0, 0, COLOR_NEUTRAL));
        issue(make_query(0, 0, 0, COLOR_NEUTRAL));
        issue(make_query(-4096, -4096, 1023, COLOR_NEUTRAL));
        issue(make_query(8191, 8191, 1023, COLOR_BLACK));
        issue(make_query(4095, 4095, 0, COLOR_BLACK));
        issue(make_query(2000, 2000, 0, COLOR_RED));
        issue(make_query(2000, 2000, 1, COLOR_RED));
        issue(make_query(2048, 2148, 0, COLOR_BLUE));
        issue(make_query(2048, 2147, 0, COLOR_BLUE));
        for (int k = 5; k < TABLE_DEPTH - 1; k++)
            issue(make_append(KIND_CIRCLE, k * 200, 100, 0, 0, COLOR_RED));
        issue(make_append(KIND_RECT, 3000, 100, 50, 60, COLOR_BLACK));
        issue(make_append(KIND_RECT, 10, 10, 10, 10, COLOR_NEUTRAL));
        issue(make_query(3000, 100, 0, COLOR_BLACK));
        issue(make_request(CMD_CLEAR));
        issue(make_query(0, 0, 1023, COLOR_NEUTRAL));

        // Random phases, each under its own pawn radius
        pawn_plan[0] = '0;
        pawn_plan[1] = '1;
        pawn_plan[2] = RAD_W'($urandom_range(0, 1023));
        pawn_plan[3] = RAD_W'(1);
        pawn_plan[4] = RAD_W'($urandom_range(0, 1023));
        pawn_plan[5] = PAWN_RESET;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain();
            write_pawn(pawn_plan[ph]);
            clear_pct = (ph % 2 == 0) ? 2 : 8;
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                burst = ($urandom_range(0, 3) == 0) ? int'($urandom_range(20, 60))
                                                     : int'($urandom_range(1, 8));
                if (burst > ITEMS_PER_PHASE - sent) burst = ITEMS_PER_PHASE - sent;
                repeat (burst) begin
                    issue(random_request(clear_pct));
                    sent++;
                end
                gap = int'($urandom_range(0, 12));
                if (gap > 0) pause(gap);
            end
        end

        drain();
        sb.close();
        $display("covered %0d queries (%0d hits), %0d clears, %0d dropped appends",
                 sb.queries, sb.hits, sb.clears, sb.drops);
        $display("across %0d pawn radius settings; %0d mismatches",
                 pawn_writes, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
